// File: rtl/core/fbk_pkg.sv
// fbk_pkg: item types, command/status bundles and constants for the fir filter bank
// used by fbk_ctrl, fbk_datapath and fir_filter_bank_core (not by fbk_ram); depends on nothing

package fbk_pkg;

   // input item: a sample or a coefficient write
   typedef struct packed {
      logic               kind;
      logic signed [15:0] sample;
      logic               gap;
      logic               restart;
      logic [2:0]         coef_channel;
      logic [5:0]         coef_tap;
      logic signed [15:0] coef_value;
   } req_item_type;

   // result item: one filter output
   typedef struct packed {
      logic [2:0]         channel;
      logic signed [23:0] value;
      logic               gap_out;
      logic               discont;
      logic               last;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic clr_wr;
      logic coef_wr;
      logic sample_wr;
      logic issue;
      logic tap_first;
      logic tap_last;
      logic chan_next;
      logic load_out;
      logic out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clr_last;
      logic window_full;
      logic acc_ready;
      logic out_free;
   } sts_type;

   localparam logic KIND_COEF = 1'b1;

   localparam logic CSR_TAPS  = 1'b0;
   localparam logic CSR_CHANS = 1'b1;

   localparam logic [6:0] TAPS_RESET  = 7'd64;
   localparam logic [3:0] CHANS_RESET = 4'd8;

   localparam logic signed [23:0] VALUE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] VALUE_MIN = 24'sh800000;

endpackage

// File: rtl/core/fbk_ram.sv
// fbk_ram: generic single write port, single read port ram with registered read data
// no dependencies

module fbk_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/fbk_ctrl.sv
// fbk_ctrl: sequencer for the fir filter bank (clearing pass, item intake, tap and channel walk)
// depends on fbk_pkg; drives the datapath through cmd_type and reads sts_type

module fbk_ctrl
   import fbk_pkg::*;
#(
   parameter int TAPS = 64,
   parameter int CHANNELS = 8,
   localparam int LW = $clog2(TAPS + 1),
   localparam int NW = $clog2(CHANNELS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [LW-1:0] act_taps,
   input  logic [NW-1:0] act_chans,
   input  logic          req_valid,
   input  logic          req_kind,
   output logic          req_stall,
   input  sts_type       sts,
   output cmd_type       cmd
);

   localparam logic [1:0] S_CLR  = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_MAC  = 2'd2;
   localparam logic [1:0] S_WAIT = 2'd3;

   logic [1:0]    state_ff, state_in;
   logic [LW-1:0] tap_ff, tap_in;
   logic [NW-1:0] chan_ff, chan_in;
   logic          tap_end;
   logic          chan_end;

   assign tap_end  = (tap_ff == LW'(act_taps - 1'b1));
   assign chan_end = (chan_ff == NW'(act_chans - 1'b1));

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      chan_in   = chan_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_kind == KIND_COEF) begin
                  cmd.coef_wr = 1'b1;
               end else begin
                  cmd.sample_wr = 1'b1;
                  if (sts.window_full) begin
                     state_in = S_MAC;
                     tap_in   = '0;
                     chan_in  = '0;
                  end
               end
            end
         end
         S_MAC: begin
            cmd.issue     = 1'b1;
            cmd.tap_first = (tap_ff == '0);
            cmd.tap_last  = tap_end;
            tap_in        = LW'(tap_ff + 1'b1);
            if (tap_end) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // hand the finished sum to the output register, then move on
            if (sts.acc_ready && sts.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = chan_end;
               if (chan_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.chan_next = 1'b1;
                  chan_in       = NW'(chan_ff + 1'b1);
                  tap_in        = '0;
                  state_in      = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         tap_ff   <= '0;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
         chan_ff  <= chan_in;
      end
   end

   // a sum must not be reported ready while its taps are still being issued
   a_no_ready_in_mac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> !sts.acc_ready)
      else $error("accumulator ready during tap walk");

   // the clear counter reaches its end only inside the clearing pass
   a_clr_end_only_in_clr: assert property (@(posedge clock) disable iff (reset)
      sts.clr_last |-> (state_ff == S_CLR))
      else $error("clear end seen outside clearing pass");

endmodule

// File: rtl/core/fbk_datapath.sv
// fbk_datapath: history and coefficient rams, window bookkeeping, multiply-accumulate
// pipeline and output register; depends on fbk_pkg and fbk_ram

module fbk_datapath
   import fbk_pkg::*;
#(
   parameter int TAPS = 64,
   parameter int CHANNELS = 8,
   localparam int LW = $clog2(TAPS + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic [LW-1:0] act_taps,
   input  req_item_type  req_data,
   input  cmd_type       cmd,
   output sts_type       sts,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_item_type  rsp_data
);

   localparam int HA  = $clog2(TAPS);
   localparam int CA  = $clog2(CHANNELS * TAPS);
   localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int AW  = 32 + HA;

   localparam logic [CA-1:0] ROW_STEP = CA'(TAPS);
   localparam logic [CA-1:0] CLR_END  = CA'(CHANNELS * TAPS - 1);
   localparam logic [HA-1:0] HIST_END = HA'(TAPS - 1);
   localparam logic [LW-1:0] TAPS_MAX = LW'(TAPS);

   // window bookkeeping
   logic [HA-1:0]  hist_wp_ff, hist_wp_in;
   logic [LW-1:0]  fill_ff, fill_in, fill_base;
   logic [LW-1:0]  gap_run_ff, gap_run_in, gap_base;
   logic           discont_ff, discont_in, disc_now;
   logic           window_full, gap_win;
   logic [LW:0]    wp_wide, taps_wide;
   logic [HA-1:0]  start_in;

   // read walk
   logic [HA-1:0]  hist_start_ff, hist_rd_ff;
   logic [CA-1:0]  coef_row_ff, coef_rd_ff;
   logic [CHW-1:0] out_ch_ff;
   logic           gap_win_ff, out_disc_ff;

   // clearing pass
   logic [CA-1:0]  clr_addr_ff;

   // coefficient ram port
   logic           coef_hit;
   logic           coef_we;
   logic [CA-1:0]  coef_waddr, coef_user_addr;
   logic [15:0]    coef_wdata;
   logic [15:0]    coef_q, hist_q;
   logic [15:0]    hist_wdata;

   // mac pipeline
   logic                 s1_vld_ff, s1_first_ff, s1_last_ff;
   logic                 s2_vld_ff, s2_first_ff, s2_last_ff;
   logic signed [31:0]   prod_ff;
   logic signed [AW-1:0] acc_ff;
   logic                 acc_ready_ff;

   // output
   logic signed [AW-1:0] acc_shift;
   logic                 fits;
   logic signed [23:0]   value_sat;
   rsp_item_type         rsp_in;
   rsp_item_type         rsp_data_ff;
   logic                 rsp_valid_ff;

   always_comb begin
      fill_base  = req_data.restart ? '0 : fill_ff;
      fill_in    = (fill_base == TAPS_MAX) ? fill_base : LW'(fill_base + 1'b1);
      gap_base   = req_data.restart ? '0 : gap_run_ff;
      if (!req_data.gap) begin
         gap_run_in = '0;
      end else begin
         gap_run_in = (gap_base == TAPS_MAX) ? gap_base : LW'(gap_base + 1'b1);
      end
      window_full = (fill_in >= act_taps);
      gap_win     = (gap_run_in >= act_taps);
      disc_now    = req_data.restart | discont_ff;
      discont_in  = window_full ? 1'b0 : disc_now;
      hist_wp_in  = (hist_wp_ff == HIST_END) ? '0 : HA'(hist_wp_ff + 1'b1);
      // oldest sample of the window sits act_taps places behind the next write slot
      wp_wide   = (LW + 1)'(hist_wp_in);
      taps_wide = (LW + 1)'(act_taps);
      if (wp_wide >= taps_wide) begin
         start_in = HA'(wp_wide - taps_wide);
      end else begin
         start_in = HA'(wp_wide + (LW + 1)'(TAPS) - taps_wide);
      end
   end

   assign hist_wdata = req_data.gap ? 16'd0 : req_data.sample;

   assign coef_hit = (int'(req_data.coef_channel) < CHANNELS) &&
                     (int'(req_data.coef_tap) < TAPS);
   assign coef_user_addr = CA'(int'(req_data.coef_channel) * TAPS + int'(req_data.coef_tap));
   assign coef_we    = cmd.clr_wr | (cmd.coef_wr & coef_hit);
   assign coef_waddr = cmd.clr_wr ? clr_addr_ff : coef_user_addr;
   assign coef_wdata = cmd.clr_wr ? 16'd0 : req_data.coef_value;

   fbk_ram #(
      .WIDTH (16),
      .DEPTH (TAPS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.sample_wr),
      .wr_addr (hist_wp_ff),
      .wr_data (hist_wdata),
      .rd_en   (cmd.issue),
      .rd_addr (hist_rd_ff),
      .rd_data (hist_q)
   );

   fbk_ram #(
      .WIDTH (16),
      .DEPTH (CHANNELS * TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (coef_wdata),
      .rd_en   (cmd.issue),
      .rd_addr (coef_rd_ff),
      .rd_data (coef_q)
   );

   // scale by 2^-15 with floor, then clip to 24 bits; a window of only gaps gives zero
   always_comb begin
      acc_shift = acc_ff >>> 15;
      fits      = (&acc_shift[AW-1:23]) | ~(|acc_shift[AW-1:23]);
      if (gap_win_ff) begin
         value_sat = '0;
      end else if (fits) begin
         value_sat = acc_shift[23:0];
      end else begin
         value_sat = acc_shift[AW-1] ? VALUE_MIN : VALUE_MAX;
      end
      rsp_in.channel = 3'(out_ch_ff);
      rsp_in.value   = value_sat;
      rsp_in.gap_out = gap_win_ff;
      rsp_in.discont = out_disc_ff;
      rsp_in.last    = cmd.out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_wp_ff   <= '0;
         fill_ff      <= '0;
         gap_run_ff   <= '0;
         discont_ff   <= 1'b1;
         clr_addr_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         acc_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_wr) begin
            clr_addr_ff <= CA'(clr_addr_ff + 1'b1);
         end
         if (cmd.sample_wr) begin
            hist_wp_ff <= hist_wp_in;
            fill_ff    <= fill_in;
            gap_run_ff <= gap_run_in;
            discont_ff <= discont_in;
         end
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         if (cmd.load_out) begin
            acc_ready_ff <= 1'b0;
         end else if (s2_vld_ff && s2_last_ff) begin
            acc_ready_ff <= 1'b1;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sample_wr) begin
         hist_start_ff <= start_in;
         hist_rd_ff    <= start_in;
         coef_row_ff   <= '0;
         coef_rd_ff    <= '0;
         out_ch_ff     <= '0;
         gap_win_ff    <= gap_win;
         out_disc_ff   <= disc_now;
      end else if (cmd.chan_next) begin
         coef_row_ff <= CA'(coef_row_ff + ROW_STEP);
         coef_rd_ff  <= CA'(coef_row_ff + ROW_STEP);
         hist_rd_ff  <= hist_start_ff;
         out_ch_ff   <= CHW'(out_ch_ff + 1'b1);
      end else if (cmd.issue) begin
         hist_rd_ff <= (hist_rd_ff == HIST_END) ? '0 : HA'(hist_rd_ff + 1'b1);
         coef_rd_ff <= CA'(coef_rd_ff + 1'b1);
      end
      s1_first_ff <= cmd.tap_first;
      s1_last_ff  <= cmd.tap_last;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      if (s1_vld_ff) begin
         prod_ff <= signed'(coef_q) * signed'(hist_q);
      end
      if (s2_vld_ff) begin
         acc_ff <= s2_first_ff ? AW'(prod_ff) : acc_ff + AW'(prod_ff);
      end
      if (cmd.load_out) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign sts.clr_last    = (clr_addr_ff == CLR_END);
   assign sts.window_full = window_full;
   assign sts.acc_ready   = acc_ready_ff;
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new channel sum must not overwrite one still waiting for the output register
   a_no_acc_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && s2_first_ff) |-> !acc_ready_ff)
      else $error("accumulator restarted before result was taken");

   // a sample only enters once the mac pipeline has drained
   a_sample_when_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.sample_wr |-> (!s1_vld_ff && !s2_vld_ff && !acc_ready_ff))
      else $error("sample item taken with mac pipeline busy");

   // loading the output needs a finished sum and a free output register
   a_load_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (acc_ready_ff && (!rsp_valid_ff || !rsp_stall)))
      else $error("output loaded without ready sum or free register");

endmodule

// File: rtl/core/fir_filter_bank_core.sv
// fir_filter_bank_core: bank of fir filters on one sample stream, one shared mac unit.
// a sample item that completes a window starts a walk over L taps for each of C channels
// in use, done by the single multiply-accumulate reading the rams; req_stall stays high
// until the last result is handed to the output register, and a result held by rsp_stall
// delays the walk. other items are taken without a stall. after reset a clearing pass
// zeroes all CHANNELS*TAPS (512) entries of the coefficient ram with req_stall high.

module fir_filter_bank_core
   import fbk_pkg::*;
#(
   parameter int TAPS = 64,
   parameter int CHANNELS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_index,
   input  logic [6:0]   csr_wr_data
);

   localparam int LW = $clog2(TAPS + 1);
   localparam int NW = $clog2(CHANNELS + 1);

   logic [6:0]    taps_ff, taps_in;
   logic [3:0]    chans_ff, chans_in;
   logic [LW-1:0] act_taps;
   logic [NW-1:0] act_chans;
   cmd_type       cmd;
   sts_type       sts;

   always_comb begin
      taps_in  = taps_ff;
      chans_in = chans_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TAPS:  taps_in  = csr_wr_data;
            CSR_CHANS: chans_in = csr_wr_data[3:0];
            default:   taps_in  = taps_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taps_ff  <= TAPS_RESET;
         chans_ff <= CHANS_RESET;
      end else begin
         taps_ff  <= taps_in;
         chans_ff <= chans_in;
      end
   end

   // zero acts as one, anything past the built size acts as the built size
   always_comb begin
      if (taps_ff == '0) begin
         act_taps = LW'(1);
      end else if (int'(taps_ff) > TAPS) begin
         act_taps = LW'(TAPS);
      end else begin
         act_taps = LW'(taps_ff);
      end
      if (chans_ff == '0) begin
         act_chans = NW'(1);
      end else if (int'(chans_ff) > CHANNELS) begin
         act_chans = NW'(CHANNELS);
      end else begin
         act_chans = NW'(chans_ff);
      end
   end

   fbk_ctrl #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .act_taps  (act_taps),
      .act_chans (act_chans),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbk_datapath #(
      .TAPS     (TAPS),
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .act_taps  (act_taps),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
